// File: rtl/core/assert_macros.svh
// Assertion macros shared by the syndrome extraction RTL.
// Depends on nothing; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every rising edge of clk while rstn is high.
`define STC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check prop on every rising edge of clk, reset included.
`define STC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STC_ASSERT(label, clk, rstn, prop, msg)
`define STC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/stc_pkg.sv
// Package for the syndrome-trellis extraction block: register map,
// reset values, column packing and default parameter values. No dependencies.
package stc_pkg;

    localparam int MAX_HEIGHT_DEF  = 16;
    localparam int MAX_WIDTH_DEF   = 4;
    localparam int LENGTH_BITS_DEF = 16;

    // Submatrix columns: 16 bits per column, four columns per 64-bit register.
    localparam int COLUMN_STRIDE = 16;
    localparam int NUM_COLUMNS   = 4;
    localparam int COL_IDX_W     = 2;

    localparam int WIDTH_W  = 3;
    localparam int HEIGHT_W = 5;
    localparam int DATA_W   = 64;
    localparam int PADDR_W  = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 5'd10;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 3'd1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COVER_LENGTH   = 3'd0,
        REG_MESSAGE_LENGTH = 3'd1,
        REG_HEIGHT         = 3'd2,
        REG_SHORT_WIDTH    = 3'd3,
        REG_LONG_WIDTH     = 3'd4,
        REG_SHORT_COLUMNS  = 3'd5,
        REG_LONG_COLUMNS   = 3'd6
    } reg_idx_t;

endpackage

// File: rtl/core/stc_syndrome_extract.sv
// Syndrome extraction for a syndrome-trellis code: top level with APB
// register file, block sizing and the syndrome window. Uses stc_pkg and
// assert_macros.svh.

// One stego element is taken per cycle while s_ready is high: each transfer
// updates the window, the column counter and the block sizing accumulators
// in the cycle it is accepted, whatever its content. A message bit is
// emitted at the end of every block into an output register backed by one
// skid stage; s_ready drops only while both hold undelivered bits. Set
// first_of_cover on the first element of every cover to restart. Block i
// is long when 2*M*(W+long_width) <= 2*(i+1)*N + M, with W the columns
// placed so far; no bits come out when message_length is zero or exceeds
// cover_length, and elements after the last bit are dropped.
`include "assert_macros.svh"

module stc_syndrome_extract #(
    parameter int MAX_HEIGHT  = stc_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH   = stc_pkg::MAX_WIDTH_DEF,
    parameter int LENGTH_BITS = stc_pkg::LENGTH_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stc_pkg::PADDR_W-1:0]    paddr,
    input  logic [stc_pkg::DATA_W-1:0]     pwdata,
    output logic [stc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    // stego elements
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_stego_value,
    input  logic                           s_first_of_cover,
    // message bits
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_message_bit,
    output logic [LENGTH_BITS-1:0]         m_message_index,
    output logic                           m_last_bit
);

    localparam int WW       = stc_pkg::WIDTH_W;
    localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SCALED_W = 2 * LENGTH_BITS + 2;
    localparam int CMP_W    = SCALED_W + 1;
    localparam int PROD_W   = LENGTH_BITS + WW;
    localparam int EXT_W    = (MAX_HEIGHT > stc_pkg::COLUMN_STRIDE) ?
                              MAX_HEIGHT : stc_pkg::COLUMN_STRIDE;
    localparam logic [WW-1:0] MAX_W_C = WW'(MAX_WIDTH);
    localparam logic [stc_pkg::HEIGHT_W-1:0] MAX_H_C = stc_pkg::HEIGHT_W'(MAX_HEIGHT);

    typedef logic [stc_pkg::NUM_COLUMNS-1:0][stc_pkg::COLUMN_STRIDE-1:0] col_set_t;

    // configuration registers
    logic [LENGTH_BITS-1:0]          cov_len_reg;
    logic [LENGTH_BITS-1:0]          msg_len_reg;
    logic [stc_pkg::HEIGHT_W-1:0]    height_reg;
    logic [WW-1:0]                   short_w_reg;
    logic [WW-1:0]                   long_w_reg;
    logic [stc_pkg::DATA_W-1:0]      short_cols_reg;
    logic [stc_pkg::DATA_W-1:0]      long_cols_reg;

    // running state
    logic [MAX_HEIGHT-1:0]  win_reg, win_next;
    logic [LENGTH_BITS-1:0] blk_reg, blk_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic                   long_reg, long_next;
    logic [SCALED_W-1:0]    placed_reg, placed_next;
    logic [SCALED_W-1:0]    target_reg, target_next;
    logic                   fin_reg, fin_next;

    // result queue: output register plus one skid stage
    logic                   out_valid_reg, skid_valid_reg;
    logic                   out_bit_reg, skid_bit_reg;
    logic [LENGTH_BITS-1:0] out_idx_reg, skid_idx_reg;
    logic                   out_last_reg, skid_last_reg;

    logic                   wr_en;
    stc_pkg::reg_idx_t      wr_idx, rd_idx;
    logic                   accept, pop, push;

    // datapath
    logic [MAX_HEIGHT-1:0]  win_eff;
    logic [LENGTH_BITS-1:0] blk_eff;
    logic [COL_W-1:0]       col_eff, col_c;
    logic                   long_eff, fin_eff, active, is_long, done;
    logic [SCALED_W-1:0]    placed_eff, target_eff;
    logic [WW-1:0]          sw, lw, w, col_inc;
    logic [stc_pkg::HEIGHT_W-1:0] h;
    logic [MAX_HEIGHT-1:0]  hmask, col_bits, win_x;
    logic [EXT_W-1:0]       col_wide;
    logic [PROD_W-1:0]      m_lw, m_w;
    logic [CMP_W-1:0]       lhs, rhs;
    col_set_t               cols;
    logic                   res_bit, res_last;
    logic [LENGTH_BITS-1:0] res_idx;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = stc_pkg::reg_idx_t'(paddr[stc_pkg::PADDR_W-1:3]);
    assign rd_idx = stc_pkg::reg_idx_t'(paddr[stc_pkg::PADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cov_len_reg    <= LENGTH_BITS'(1);
            msg_len_reg    <= LENGTH_BITS'(1);
            height_reg     <= stc_pkg::HEIGHT_RST;
            short_w_reg    <= stc_pkg::WIDTH_RST;
            long_w_reg     <= stc_pkg::WIDTH_RST;
            short_cols_reg <= '0;
            long_cols_reg  <= '0;
        end else if (wr_en) begin
            unique case (wr_idx)
                stc_pkg::REG_COVER_LENGTH:   cov_len_reg    <= pwdata[LENGTH_BITS-1:0];
                stc_pkg::REG_MESSAGE_LENGTH: msg_len_reg    <= pwdata[LENGTH_BITS-1:0];
                stc_pkg::REG_HEIGHT:         height_reg     <= pwdata[stc_pkg::HEIGHT_W-1:0];
                stc_pkg::REG_SHORT_WIDTH:    short_w_reg    <= pwdata[WW-1:0];
                stc_pkg::REG_LONG_WIDTH:     long_w_reg     <= pwdata[WW-1:0];
                stc_pkg::REG_SHORT_COLUMNS:  short_cols_reg <= pwdata;
                stc_pkg::REG_LONG_COLUMNS:   long_cols_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rd_idx)
            stc_pkg::REG_COVER_LENGTH:   prdata = stc_pkg::DATA_W'(cov_len_reg);
            stc_pkg::REG_MESSAGE_LENGTH: prdata = stc_pkg::DATA_W'(msg_len_reg);
            stc_pkg::REG_HEIGHT:         prdata = stc_pkg::DATA_W'(height_reg);
            stc_pkg::REG_SHORT_WIDTH:    prdata = stc_pkg::DATA_W'(short_w_reg);
            stc_pkg::REG_LONG_WIDTH:     prdata = stc_pkg::DATA_W'(long_w_reg);
            stc_pkg::REG_SHORT_COLUMNS:  prdata = short_cols_reg;
            stc_pkg::REG_LONG_COLUMNS:   prdata = long_cols_reg;
            default:                     prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign push    = accept && active && done;

    // ---------------- per-element update ----------------
    always_comb begin
        // first_of_cover restarts the cover before the element is used
        win_eff    = s_first_of_cover ? '0   : win_reg;
        blk_eff    = s_first_of_cover ? '0   : blk_reg;
        col_eff    = s_first_of_cover ? '0   : col_reg;
        long_eff   = s_first_of_cover ? 1'b0 : long_reg;
        placed_eff = s_first_of_cover ? '0   : placed_reg;
        target_eff = s_first_of_cover ? '0   : target_reg;
        fin_eff    = s_first_of_cover ? 1'b0 : fin_reg;

        active = !fin_eff && (msg_len_reg != '0) && (msg_len_reg <= cov_len_reg);

        sw = (short_w_reg == '0) ? WW'(1) : ((short_w_reg > MAX_W_C) ? MAX_W_C : short_w_reg);
        lw = (long_w_reg == '0)  ? WW'(1) : ((long_w_reg > MAX_W_C) ? MAX_W_C : long_w_reg);
        h  = (height_reg > MAX_H_C) ? MAX_H_C : height_reg;
        for (int j = 0; j < MAX_HEIGHT; j++) begin
            hmask[j] = (stc_pkg::HEIGHT_W'(j) < h);
        end

        // long-block test, only at the start of a block
        m_lw = PROD_W'(msg_len_reg) * PROD_W'(lw);
        lhs  = CMP_W'(placed_eff) + CMP_W'({m_lw, 1'b0});
        rhs  = CMP_W'(target_eff) + CMP_W'({cov_len_reg, 1'b0}) + CMP_W'(msg_len_reg);
        is_long = (col_eff == '0) ? (lhs <= rhs) : long_eff;

        w     = is_long ? lw : sw;
        // clip a stale column position against the current width
        col_c = (WW'(col_eff) >= w) ? COL_W'(w - WW'(1)) : col_eff;
        cols  = is_long ? col_set_t'(long_cols_reg) : col_set_t'(short_cols_reg);
        col_wide = EXT_W'(cols[stc_pkg::COL_IDX_W'(col_c)]);
        col_bits = col_wide[MAX_HEIGHT-1:0];

        win_x   = (s_stego_value != 8'd0) ? (win_eff ^ (col_bits & hmask)) : win_eff;
        col_inc = WW'(col_c) + WW'(1);
        done    = (col_inc >= w);

        res_bit  = win_x[0];
        res_idx  = blk_eff;
        res_last = (blk_eff == (msg_len_reg - LENGTH_BITS'(1)));

        m_w = PROD_W'(msg_len_reg) * PROD_W'(w);

        win_next    = win_eff;
        blk_next    = blk_eff;
        col_next    = col_eff;
        long_next   = long_eff;
        placed_next = placed_eff;
        target_next = target_eff;
        fin_next    = fin_eff;
        if (active) begin
            long_next = is_long;
            if (done) begin
                win_next    = win_x >> 1;
                blk_next    = blk_eff + LENGTH_BITS'(1);
                col_next    = '0;
                placed_next = placed_eff + SCALED_W'({m_w, 1'b0});
                target_next = target_eff + SCALED_W'({cov_len_reg, 1'b0});
                fin_next    = res_last;
            end else begin
                win_next = win_x;
                col_next = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= '0;
            blk_reg    <= '0;
            col_reg    <= '0;
            long_reg   <= 1'b0;
            placed_reg <= '0;
            target_reg <= '0;
            fin_reg    <= 1'b0;
        end else if (accept) begin
            win_reg    <= win_next;
            blk_reg    <= blk_next;
            col_reg    <= col_next;
            long_reg   <= long_next;
            placed_reg <= placed_next;
            target_reg <= target_next;
            fin_reg    <= fin_next;
        end
    end

    // ---------------- result queue ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg && pop) begin
                // advance the skid entry into the output register
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (push && out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else if (push) begin
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg && pop) begin
            out_bit_reg  <= skid_bit_reg;
            out_idx_reg  <= skid_idx_reg;
            out_last_reg <= skid_last_reg;
        end else if (push && (!out_valid_reg || pop)) begin
            out_bit_reg  <= res_bit;
            out_idx_reg  <= res_idx;
            out_last_reg <= res_last;
        end
        if (push && out_valid_reg && !pop) begin
            skid_bit_reg  <= res_bit;
            skid_idx_reg  <= res_idx;
            skid_last_reg <= res_last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_message_bit   = out_bit_reg;
    assign m_message_index = out_idx_reg;
    assign m_last_bit      = out_last_reg;

    // ---------------- checks ----------------
    `STC_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg, "skid holds a bit while output register is empty")
    `STC_ASSERT(a_col_in_range, aclk, aresetn, WW'(col_reg) < MAX_W_C, "column position beyond maximum width")
    `STC_ASSERT(a_finish_on_last, aclk, aresetn, $rose(fin_reg) |-> $past(push && res_last), "finished set without last message bit")
    `STC_ASSERT(a_index_advance, aclk, aresetn, push |=> (blk_reg == $past(res_idx) + LENGTH_BITS'(1)), "block number did not advance after a message bit")

endmodule

// File: tb/stc_syndrome_checker.sv
// Checker for stc_syndrome_extract: mirrors the register file from the APB
// writes, predicts every message bit from the stego transfers and compares
// each delivered bit with the oldest prediction. Uses stc_pkg.
`timescale 1ns / 100ps

module stc_syndrome_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [stc_pkg::PADDR_W-1:0] paddr,
    input  logic [stc_pkg::DATA_W-1:0]  pwdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [7:0]                  s_stego_value,
    input  logic                        s_first_of_cover,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_message_bit,
    input  logic [15:0]                 m_message_index,
    input  logic                        m_last_bit,
    output int                          mismatches,
    output int                          pending,
    output int                          bits_checked
);
    localparam int HMAX = stc_pkg::MAX_HEIGHT_DEF;
    localparam int WMAX = stc_pkg::MAX_WIDTH_DEF;

    typedef struct packed {
        logic        bit_val;
        logic [15:0] index;
        logic        last;
    } message_bit_t;

    message_bit_t expected_bits[$];
    int mismatch_cnt = 0;
    int checked_cnt = 0;

    // register mirror
    logic [15:0] cfg_cover_len;
    logic [15:0] cfg_msg_len;
    logic [4:0]  cfg_height;
    logic [2:0]  cfg_short_w;
    logic [2:0]  cfg_long_w;
    logic [63:0] cfg_short_cols;
    logic [63:0] cfg_long_cols;

    // running extraction state
    logic [15:0] window;
    logic [15:0] block_num;
    logic [2:0]  col_pos;
    logic        long_blk;
    logic [33:0] placed_acc;
    logic [33:0] target_acc;
    logic        done;

    function automatic logic [2:0] fit_width(input logic [2:0] w);
        if (w == 0) return 3'd1;
        if (w > WMAX) return 3'(WMAX);
        return w;
    endfunction

    task automatic clear_running();
        window = '0;
        block_num = '0;
        col_pos = '0;
        long_blk = 1'b0;
        placed_acc = '0;
        target_acc = '0;
        done = 1'b0;
    endtask

    task automatic extract_bit(input logic [7:0] value, input logic first);
        logic [63:0]  n, m, cols, lhs, rhs;
        logic [2:0]   sw, lw, w;
        logic [4:0]   h;
        logic [16:0]  span;
        logic [15:0]  hmask, colbits;
        message_bit_t rec;
        if (first) clear_running();
        n = 64'(cfg_cover_len);
        m = 64'(cfg_msg_len);
        if (done || m == 0 || m > n) return;
        sw = fit_width(cfg_short_w);
        lw = fit_width(cfg_long_w);
        h = (cfg_height > HMAX) ? 5'(HMAX) : cfg_height;
        span = (17'd1 << h) - 17'd1;
        hmask = span[15:0];
        // size the block on its first column
        if (col_pos == 0) begin
            lhs = 64'(placed_acc) + 64'd2 * m * 64'(lw);
            rhs = 64'(target_acc) + 64'd2 * n + m;
            long_blk = (lhs <= rhs);
        end
        w = long_blk ? lw : sw;
        cols = long_blk ? cfg_long_cols : cfg_short_cols;
        if (col_pos >= w) col_pos = w - 3'd1;
        if (value != 8'd0) begin
            colbits = 16'(cols >> (16 * col_pos));
            window = window ^ (colbits & hmask);
        end
        col_pos = col_pos + 3'd1;
        if (col_pos < w) return;
        rec.bit_val = window[0];
        rec.index = block_num;
        rec.last = (64'(block_num) == m - 64'd1);
        expected_bits.push_back(rec);
        window = window >> 1;
        placed_acc = 34'(64'(placed_acc) + 64'd2 * m * 64'(w));
        target_acc = 34'(64'(target_acc) + 64'd2 * n);
        block_num = block_num + 16'd1;
        col_pos = '0;
        if (rec.last) done = 1'b1;
    endtask

    always @(posedge aclk) begin
        message_bit_t exp_bit;
        if (!aresetn) begin
            cfg_cover_len = 16'd1;
            cfg_msg_len = 16'd1;
            cfg_height = stc_pkg::HEIGHT_RST;
            cfg_short_w = stc_pkg::WIDTH_RST;
            cfg_long_w = stc_pkg::WIDTH_RST;
            cfg_short_cols = '0;
            cfg_long_cols = '0;
            clear_running();
            expected_bits.delete();
        end else begin
            // retire before predicting so a fresh bit is never matched early
            if (m_valid && m_ready) begin
                checked_cnt++;
                if (expected_bits.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected message bit %0b index %0d last %0b",
                                 $realtime, m_message_bit, m_message_index, m_last_bit);
                end else begin
                    exp_bit = expected_bits.pop_front();
                    if (m_message_bit !== exp_bit.bit_val || m_message_index !== exp_bit.index
                            || m_last_bit !== exp_bit.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: expected bit %0b index %0d last %0b, got %0b %0d %0b",
                                     $realtime, exp_bit.bit_val, exp_bit.index, exp_bit.last,
                                     m_message_bit, m_message_index, m_last_bit);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (stc_pkg::reg_idx_t'(paddr[stc_pkg::PADDR_W-1:3]))
                    stc_pkg::REG_COVER_LENGTH:   cfg_cover_len = pwdata[15:0];
                    stc_pkg::REG_MESSAGE_LENGTH: cfg_msg_len = pwdata[15:0];
                    stc_pkg::REG_HEIGHT:         cfg_height = pwdata[4:0];
                    stc_pkg::REG_SHORT_WIDTH:    cfg_short_w = pwdata[2:0];
                    stc_pkg::REG_LONG_WIDTH:     cfg_long_w = pwdata[2:0];
                    stc_pkg::REG_SHORT_COLUMNS:  cfg_short_cols = pwdata;
                    stc_pkg::REG_LONG_COLUMNS:   cfg_long_cols = pwdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) extract_bit(s_stego_value, s_first_of_cover);
        end
        pending <= expected_bits.size();
        mismatches <= mismatch_cnt;
        bits_checked <= checked_cnt;
    end

endmodule

// File: tb/tb_stc_syndrome_extract.sv
// Top of the stc_syndrome_extract testbench: clock, reset, register setup,
// stego stimulus and the verdict. Uses stc_pkg and stc_syndrome_checker.
`timescale 1ns / 100ps

module tb_stc_syndrome_extract;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [stc_pkg::PADDR_W-1:0] paddr;
    logic [stc_pkg::DATA_W-1:0]  pwdata;
    logic [stc_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        s_valid;
    logic                        s_ready;
    logic [7:0]                  s_stego_value;
    logic                        s_first_of_cover;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_message_bit;
    logic [15:0]                 m_message_index;
    logic                        m_last_bit;

    int mismatches;
    int pending;
    int bits_checked;

    int  elements_sent = 0;
    int  settings_used = 0;
    int  hold_requests = 0;
    bit  calm = 1'b0;

    stc_syndrome_extract dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stego_value    (s_stego_value),
        .s_first_of_cover (s_first_of_cover),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_message_bit    (m_message_bit),
        .m_message_index  (m_message_index),
        .m_last_bit       (m_last_bit)
    );

    stc_syndrome_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stego_value    (s_stego_value),
        .s_first_of_cover (s_first_of_cover),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_message_bit    (m_message_bit),
        .m_message_index  (m_message_index),
        .m_last_bit       (m_last_bit),
        .mismatches       (mismatches),
        .pending          (pending),
        .bits_checked     (bits_checked)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random back-pressure plus one long hold on request
    initial begin
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    function automatic logic [7:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'h00;
        if (r < 45) return 8'hFF;
        if (r < 50) return 8'h01;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic write_reg(input stc_pkg::reg_idx_t idx, input logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= stc_pkg::PADDR_W'(idx * 8);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // drop valid and wait for every predicted bit, then let the pipe settle
    task automatic drain_bits();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_settings(input int n, input int m, input int h, input int sw,
                                 input int lw, input logic [63:0] short_cols,
                                 input logic [63:0] long_cols);
        drain_bits();
        write_reg(stc_pkg::REG_COVER_LENGTH, 64'(n));
        write_reg(stc_pkg::REG_MESSAGE_LENGTH, 64'(m));
        write_reg(stc_pkg::REG_HEIGHT, 64'(h));
        write_reg(stc_pkg::REG_SHORT_WIDTH, 64'(sw));
        write_reg(stc_pkg::REG_LONG_WIDTH, 64'(lw));
        write_reg(stc_pkg::REG_SHORT_COLUMNS, short_cols);
        write_reg(stc_pkg::REG_LONG_COLUMNS, long_cols);
        settings_used++;
    endtask

    task automatic send_element(input logic [7:0] value, input logic first);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 25) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_stego_value <= value;
        s_first_of_cover <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        elements_sent++;
    endtask

    // one cover, sometimes cut short, restarted mid-way or trailed by extra elements
    task automatic send_cover(input int len);
        int count;
        int extra;
        count = len;
        if ($urandom_range(0, 9) == 0) count = $urandom_range(1, len);
        for (int i = 0; i < count; i++)
            send_element(pick_value(), (i == 0) || ($urandom_range(0, 99) == 0));
        if ($urandom_range(0, 9) == 0) begin
            extra = $urandom_range(1, 4);
            for (int i = 0; i < extra; i++) send_element(pick_value(), 1'b0);
        end
    endtask

    initial begin
        int n, m, h, sw, lw, kind, covers, len, phase;
        logic [63:0] short_cols, long_cols;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_stego_value <= '0;
        s_first_of_cover <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one bit, then an element past the end that is dropped
        send_element(8'hFF, 1'b1);
        send_element(8'h01, 1'b0);

        // mixed short and long blocks, full height
        load_settings(8, 3, 16, 2, 3, 64'hFFFF_0F0F_00FF_8001, 64'h1234_5678_9ABC_DEF0);
        send_element(8'h00, 1'b1);
        send_element(8'hFF, 1'b0);
        send_element(8'h01, 1'b0);
        send_element(8'h80, 1'b0);
        send_element(8'h7F, 1'b0);
        send_element(8'hFE, 1'b0);
        send_element(8'hAA, 1'b0);
        send_element(8'h55, 1'b0);

        // message longer than cover: nothing comes out
        load_settings(3, 4, 10, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 3; i++) send_element(8'hFF, i == 0);

        // empty message
        load_settings(4, 0, 10, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_element(8'hFF, 1'b1);
        send_element(8'h01, 1'b0);

        // zero height and zero widths
        load_settings(4, 4, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_element(8'hFF, 1'b1);
        send_element(8'hFF, 1'b0);
        send_element(8'h01, 1'b0);
        send_element(8'h80, 1'b0);

        // height and widths above their maxima
        load_settings(8, 2, 31, 7, 7, {$urandom, $urandom}, {$urandom, $urandom});
        for (int i = 0; i < 8; i++) send_element(pick_value(), i == 0);

        phase = 0;
        while (elements_sent < 1750) begin
            kind = $urandom_range(0, 99);
            covers = $urandom_range(1, 3);
            calm = (phase >= 5 && phase <= 7);
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = $urandom_range(17, 31);
                default: h = $urandom_range(1, 16);
            endcase
            short_cols = {$urandom, $urandom};
            long_cols = {$urandom, $urandom};
            if (phase == 3) begin
                // one bit per element so the output side backs up
                n = 48;
                m = 48;
                sw = 1;
                lw = 1;
                len = n;
                covers = 2;
            end else if (kind < 65) begin
                n = $urandom_range(1, 48);
                m = $urandom_range((n + 3) / 4, n);
                sw = n / m;
                lw = (n + m - 1) / m;
                len = n;
            end else if (kind < 75 || calm) begin
                // long cover, only its head is sent
                n = 65535;
                m = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(16384, 65535);
                sw = n / m;
                lw = (n + m - 1) / m;
                len = calm ? 200 : $urandom_range(40, 120);
                covers = 1;
            end else if (kind < 88) begin
                n = $urandom_range(1, 40);
                m = $urandom_range(0, n);
                sw = $urandom_range(0, 7);
                lw = $urandom_range(0, 7);
                len = n + $urandom_range(0, 6);
            end else begin
                n = $urandom_range(1, 30);
                m = $urandom_range(n + 1, n + 8);
                sw = $urandom_range(1, 4);
                lw = $urandom_range(1, 4);
                len = n;
            end
            load_settings(n, m, h, sw, lw, short_cols, long_cols);
            if (phase == 3) hold_requests++;
            for (int c = 0; c < covers; c++) send_cover(len);
            phase++;
        end
        calm = 1'b0;

        drain_bits();
        repeat (16) @(posedge aclk);
        $display("Sent %0d stego elements under %0d settings; %0d message bits compared.",
                 elements_sent, settings_used, bits_checked);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/stc_pkg.sv
rtl/core/stc_syndrome_extract.sv
tb/stc_syndrome_checker.sv
tb/tb_stc_syndrome_extract.sv
